@@ hdl/double_decimal_round_half_even_top_macros.svh @@
// Assertion macros shared by the block's checking code
`ifndef DOUBLE_DECIMAL_ROUND_HALF_EVEN_TOP_MACROS_SVH
`define DOUBLE_DECIMAL_ROUND_HALF_EVEN_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle
`define DDR_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle implication failed");

// Check that a condition implies another in the next cycle
`define DDR_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle implication failed");

`endif

@@ hdl/ddr_pkg.sv @@
package ddr_pkg;

	localparam int MAX_DIGITS = 15;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_DIGITS     = 2'd1;
	localparam logic [1:0] ST_NOT_FINITE = 2'd2;
	localparam logic [1:0] ST_OVERFLOW   = 2'd3;

	localparam logic [10:0] EXP_ALL = 11'h7FF;

	// Control carried alongside the first product
	typedef struct packed {
		logic        sign;
		logic        zero;
		logic [1:0]  st;
		logic [3:0]  dig;
		logic [63:0] vb;
	} ctl_t;

	// Control carried alongside the second product
	typedef struct packed {
		logic        pass;
		logic        zero;
		logic        sign;
		logic [1:0]  st;
		logic [63:0] vb;
	} ctl2_t;

	// Exact binary64 of ten to the digits
	function automatic logic [63:0] pow_up(input logic [3:0] d);
		logic [63:0] r;
		case (d)
			4'd0:  r = 64'h3FF0000000000000;
			4'd1:  r = 64'h4024000000000000;
			4'd2:  r = 64'h4059000000000000;
			4'd3:  r = 64'h408F400000000000;
			4'd4:  r = 64'h40C3880000000000;
			4'd5:  r = 64'h40F86A0000000000;
			4'd6:  r = 64'h412E848000000000;
			4'd7:  r = 64'h416312D000000000;
			4'd8:  r = 64'h4197D78400000000;
			4'd9:  r = 64'h41CDCD6500000000;
			4'd10: r = 64'h4202A05F20000000;
			4'd11: r = 64'h42374876E8000000;
			4'd12: r = 64'h426D1A94A2000000;
			4'd13: r = 64'h42A2309CE5400000;
			4'd14: r = 64'h42D6BCC41E900000;
			4'd15: r = 64'h430C6BF526340000;
			default: r = 64'h3FF0000000000000;
		endcase
		return r;
	endfunction

	// Nearest binary64 of ten to the minus digits
	function automatic logic [63:0] pow_down(input logic [3:0] d);
		logic [63:0] r;
		case (d)
			4'd0:  r = 64'h3FF0000000000000;
			4'd1:  r = 64'h3FB999999999999A;
			4'd2:  r = 64'h3F847AE147AE147B;
			4'd3:  r = 64'h3F50624DD2F1A9FC;
			4'd4:  r = 64'h3F1A36E2EB1C432D;
			4'd5:  r = 64'h3EE4F8B588E368F1;
			4'd6:  r = 64'h3EB0C6F7A0B5ED8D;
			4'd7:  r = 64'h3E7AD7F29ABCAF48;
			4'd8:  r = 64'h3E45798EE2308C3A;
			4'd9:  r = 64'h3E112E0BE826D695;
			4'd10: r = 64'h3DDB7CDFD9D7BDBB;
			4'd11: r = 64'h3DA5FD7FE1796495;
			4'd12: r = 64'h3D719799812DEA11;
			4'd13: r = 64'h3D3C25C268497682;
			4'd14: r = 64'h3D06849B86A12B9B;
			4'd15: r = 64'h3CD203AF9EE75616;
			default: r = 64'h3FF0000000000000;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/ddr_in_if.sv @@
interface ddr_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;
	logic [5:0]  fraction_digits;

	modport source (output valid, output value_bits, output fraction_digits, input ready);
	modport sink (input valid, input value_bits, input fraction_digits, output ready);
endinterface

@@ hdl/ddr_out_if.sv @@
interface ddr_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_bits;
	logic [1:0]  status;

	modport source (output valid, output result_bits, output status, input ready);
	modport sink (input valid, input result_bits, input status, output ready);
endinterface

@@ hdl/ddr_fmul.sv @@
// Three-stage binary64 mantissa multiply, round to nearest even.
// Both operands are normal; the product never underflows here.
module ddr_fmul #(
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic [2:0]     en,
	input  logic [52:0]    a_man,
	input  logic [10:0]    a_exp,
	input  logic [52:0]    b_man,
	input  logic [10:0]    b_exp,
	input  logic [SBW-1:0] sb_in,
	output logic [51:0]    r_frac,
	output logic [10:0]    r_exp,
	output logic           r_ovf,
	output logic [SBW-1:0] sb_out
);

	logic [53:0]    hh_s1;
	logic [52:0]    hl_s1;
	logic [52:0]    lh_s1;
	logic [51:0]    ll_s1;
	logic [12:0]    eb_s1;
	logic [SBW-1:0] sb_s1;

	logic [105:0]   prod_s2;
	logic [12:0]    eb_s2;
	logic [SBW-1:0] sb_s2;

	logic [105:0] sum;
	logic         hi;
	logic [52:0]  mant;
	logic         guard;
	logic         sticky;
	logic         rnd;
	logic [53:0]  mrnd;
	logic [12:0]  efin;

	// Form partial products of the split mantissas
	always_ff @(posedge clk) begin
		if (en[0]) begin
			hh_s1 <= a_man[52:26] * b_man[52:26];
			hl_s1 <= a_man[52:26] * b_man[25:0];
			lh_s1 <= a_man[25:0] * b_man[52:26];
			ll_s1 <= a_man[25:0] * b_man[25:0];
			eb_s1 <= 13'(a_exp) + 13'(b_exp) - 13'd1023;
			sb_s1 <= sb_in;
		end
	end

	// Add partial products
	assign sum = (106'(hh_s1) << 52) + ((106'(hl_s1) + 106'(lh_s1)) << 26) + 106'(ll_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s2 <= sum;
			eb_s2   <= eb_s1;
			sb_s2   <= sb_s1;
		end
	end

	// Normalize by one place and round to nearest even
	always_comb begin
		hi     = prod_s2[105];
		mant   = hi ? prod_s2[105:53] : prod_s2[104:52];
		guard  = hi ? prod_s2[52] : prod_s2[51];
		sticky = hi ? (|prod_s2[51:0]) : (|prod_s2[50:0]);
		rnd    = guard & (sticky | mant[0]);
		mrnd   = {1'b0, mant} + 54'(rnd);
		efin   = eb_s2 + 13'(hi) + 13'(mrnd[53]);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			r_frac <= mrnd[53] ? 52'd0 : mrnd[51:0];
			r_exp  <= efin[10:0];
			r_ovf  <= !efin[12] && (efin[11:0] >= 12'd2047);
			sb_out <= sb_s2;
		end
	end

endmodule

@@ hdl/ddr_rint.sv @@
// One-stage round to integer, ties to even, on a normal binary64.
module ddr_rint #(
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           en,
	input  logic [51:0]    frac_in,
	input  logic [10:0]    exp_in,
	input  logic           ovf_in,
	input  logic           zero_in,
	input  logic [SBW-1:0] sb_in,
	output logic [52:0]    man_out,
	output logic [10:0]    exp_out,
	output logic           zero_out,
	output logic           pass_out,
	output logic [SBW-1:0] sb_out
);

	logic        big;
	logic        tiny;
	logic [5:0]  fb;
	logic [53:0] mm;
	logic [53:0] unit;
	logic [53:0] mask;
	logic [53:0] half;
	logic [53:0] rem;
	logic        odd;
	logic        up;
	logic [53:0] mr;

	// Drop the fraction bits and round up on more than half or odd tie
	always_comb begin
		big  = exp_in >= 11'd1075;
		tiny = exp_in < 11'd1022;
		fb   = 6'(11'd1075 - exp_in);
		mm   = {2'b01, frac_in};
		unit = 54'd1 << fb;
		mask = unit - 54'd1;
		half = unit >> 1;
		rem  = mm & mask;
		odd  = |(mm & unit);
		up   = (rem > half) || ((rem == half) && odd);
		mr   = big ? mm : ((mm & ~mask) + (up ? unit : 54'd0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			man_out  <= mr[53] ? {1'b1, 52'd0} : mr[52:0];
			exp_out  <= exp_in + 11'(mr[53]);
			zero_out <= zero_in || (!big && tiny) || (mr == 54'd0);
			pass_out <= ovf_in;
			sb_out   <= sb_in;
		end
	end

endmodule

@@ hdl/double_decimal_round_half_even_top.sv @@
// Channel | Dir | Payload                          | Handshake
// din     | in  | value_bits[63:0], fraction_digits[5:0] | valid/ready
// dout    | out | result_bits[63:0], status[1:0]   | valid/ready
//
// Nine register stages: decode, three for the scaling multiply, one for the
// integer rounding, three for the descaling multiply, one output select.
// One transaction per cycle while dout is not stalled. Reset clears only
// the stage valid bits. Each stage holds while its successor is full and
// stalled; bubbles let new transactions enter even while the output waits.
`include "double_decimal_round_half_even_top_macros.svh"

module double_decimal_round_half_even_top #(
	parameter int MAX_DIGITS = ddr_pkg::MAX_DIGITS
) (
	input logic    clk,
	input logic    arst_n,
	ddr_in_if.sink   din,
	ddr_out_if.source dout
);

	localparam int SB1 = $bits(ddr_pkg::ctl_t);
	localparam int SB2 = $bits(ddr_pkg::ctl2_t);

	logic [9:1]  v;
	logic [10:1] en;

	logic [52:0]    a_man_s1;
	logic [10:0]    a_exp_s1;
	logic [52:0]    b_man_s1;
	logic [10:0]    b_exp_s1;
	ddr_pkg::ctl_t  ctl_s1;

	logic [51:0]    m1_frac;
	logic [10:0]    m1_exp;
	logic           m1_ovf;
	logic [SB1-1:0] m1_sb;
	ddr_pkg::ctl_t  m1_ctl;

	logic [52:0]    ri_man;
	logic [10:0]    ri_exp;
	logic           ri_zero;
	logic           ri_pass;
	logic [SB1-1:0] ri_sb;
	ddr_pkg::ctl_t  ri_ctl;
	ddr_pkg::ctl2_t ri_ctl2;
	logic [63:0]    pd;

	logic [51:0]    m2_frac;
	logic [10:0]    m2_exp;
	logic           m2_ovf;
	logic [SB2-1:0] m2_sb;
	ddr_pkg::ctl2_t m2_ctl;

	logic [63:0] rb;
	logic [1:0]  st;
	logic [63:0] res_s9;
	logic [1:0]  st_s9;
	logic [63:0] up_bits;
	logic        bad_digits;
	ddr_pkg::ctl_t dec;

	// Stage enables: load when empty or when the next stage moves
	always_comb begin
		en[10] = dout.ready;
		for (int k = 9; k >= 1; k--) begin
			en[k] = !v[k] || en[k+1];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			for (int k = 1; k <= 9; k++) begin
				if (en[k]) begin
					v[k] <= (k == 1) ? din.valid : v[k-1];
				end
			end
		end
	end

	assign din.ready   = en[1];
	assign dout.valid  = v[9];
	assign dout.result_bits = res_s9;
	assign dout.status = st_s9;

	// Decode input and look up scale factor
	always_comb begin
		bad_digits = 32'(din.fraction_digits) > MAX_DIGITS;
		dec.sign = din.value_bits[63];
		dec.zero = din.value_bits[62:52] == 11'd0;
		dec.dig  = din.fraction_digits[3:0];
		dec.vb   = din.value_bits;
		if (bad_digits) begin
			dec.st = ddr_pkg::ST_DIGITS;
		end else if (din.value_bits[62:52] == ddr_pkg::EXP_ALL) begin
			dec.st = ddr_pkg::ST_NOT_FINITE;
		end else begin
			dec.st = ddr_pkg::ST_OK;
		end
		up_bits = ddr_pkg::pow_up(din.fraction_digits[3:0]);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_man_s1 <= {1'b1, din.value_bits[51:0]};
			a_exp_s1 <= din.value_bits[62:52];
			b_man_s1 <= {1'b1, up_bits[51:0]};
			b_exp_s1 <= up_bits[62:52];
			ctl_s1   <= dec;
		end
	end

	// Scale by ten to the digits
	ddr_fmul #(.SBW(SB1)) u_mul_up (
		.clk    (clk),
		.en     (en[4:2]),
		.a_man  (a_man_s1),
		.a_exp  (a_exp_s1),
		.b_man  (b_man_s1),
		.b_exp  (b_exp_s1),
		.sb_in  (ctl_s1),
		.r_frac (m1_frac),
		.r_exp  (m1_exp),
		.r_ovf  (m1_ovf),
		.sb_out (m1_sb)
	);

	assign m1_ctl = ddr_pkg::ctl_t'(m1_sb);

	// Round the scaled value to an integer
	ddr_rint #(.SBW(SB1)) u_rint (
		.clk      (clk),
		.en       (en[5]),
		.frac_in  (m1_frac),
		.exp_in   (m1_exp),
		.ovf_in   (m1_ovf),
		.zero_in  (m1_ctl.zero),
		.sb_in    (m1_sb),
		.man_out  (ri_man),
		.exp_out  (ri_exp),
		.zero_out (ri_zero),
		.pass_out (ri_pass),
		.sb_out   (ri_sb)
	);

	always_comb begin
		ri_ctl       = ddr_pkg::ctl_t'(ri_sb);
		ri_ctl2.pass = ri_pass;
		ri_ctl2.zero = ri_zero;
		ri_ctl2.sign = ri_ctl.sign;
		ri_ctl2.st   = ri_ctl.st;
		ri_ctl2.vb   = ri_ctl.vb;
		pd           = ddr_pkg::pow_down(ri_ctl.dig);
	end

	// Scale back by ten to the minus digits
	ddr_fmul #(.SBW(SB2)) u_mul_down (
		.clk    (clk),
		.en     (en[8:6]),
		.a_man  (ri_man),
		.a_exp  (ri_exp),
		.b_man  ({1'b1, pd[51:0]}),
		.b_exp  (pd[62:52]),
		.sb_in  (ri_ctl2),
		.r_frac (m2_frac),
		.r_exp  (m2_exp),
		.r_ovf  (m2_ovf),
		.sb_out (m2_sb)
	);

	// Select the final result and status
	always_comb begin
		m2_ctl = ddr_pkg::ctl2_t'(m2_sb);
		st     = m2_ctl.st;
		if (m2_ctl.st != ddr_pkg::ST_OK) begin
			rb = 64'd0;
		end else if (m2_ctl.pass) begin
			rb = m2_ctl.vb;
		end else if (m2_ctl.zero) begin
			rb = {m2_ctl.sign, 63'd0};
		end else begin
			rb = {m2_ctl.sign, m2_exp, m2_frac};
		end
		if ((st == ddr_pkg::ST_OK) && (m2_ovf || (rb[62:52] == ddr_pkg::EXP_ALL))) begin
			st = ddr_pkg::ST_OVERFLOW;
			rb = 64'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			res_s9 <= rb;
			st_s9  <= st;
		end
	end

	// An error status always carries a zero result
	`DDR_ASSERT_IMP(a_err_zero, dout.valid && (dout.status != ddr_pkg::ST_OK), dout.result_bits == 64'd0)
	// An empty first stage always takes input
	`DDR_ASSERT_IMP(a_bubble_ready, !v[1], din.ready)
	// A full stalled first stage keeps its transaction
	`DDR_ASSERT_NXT(a_s1_hold, v[1] && !en[1], v[1])

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	typedef struct {
		logic [63:0] result_bits;
		logic [1:0]  status;
	} rounded_t;

	logic clk;
	logic arst_n;
	int   errors = 0;

	ddr_in_if  din_if();
	ddr_out_if dout_if();

	rounded_t pending_results[$];

	// Exact powers of ten and nearest powers of one tenth
	real ten_up [16] = '{1.0, 1e1, 1e2, 1e3, 1e4, 1e5, 1e6, 1e7,
		1e8, 1e9, 1e10, 1e11, 1e12, 1e13, 1e14, 1e15};
	real ten_down [16] = '{1.0, 1e-1, 1e-2, 1e-3, 1e-4, 1e-5, 1e-6, 1e-7,
		1e-8, 1e-9, 1e-10, 1e-11, 1e-12, 1e-13, 1e-14, 1e-15};

	double_decimal_round_half_even_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Round a finite binary64 to an integer, ties to even, keeping the sign
	function automatic logic [63:0] round_to_int_even(logic [63:0] b);
		logic        sgn;
		logic [10:0] e;
		logic [63:0] m, q, rem, half;
		int          fb;
		sgn = b[63];
		e = b[62:52];
		if (e >= 11'd1075)
			return b;
		if (e < 11'd1022)
			return {sgn, 63'd0};
		if (e == 11'd1022) begin
			if (b[51:0] == 52'd0)
				return {sgn, 63'd0};
			return {sgn, 63'h3FF0000000000000};
		end
		m = {11'd0, 1'b1, b[51:0]};
		fb = 1075 - e;
		q = m >> fb;
		rem = m & ((64'd1 << fb) - 64'd1);
		half = 64'd1 << (fb - 1);
		if (rem > half || (rem == half && q[0]))
			q++;
		return $realtobits(real'(q)) | {sgn, 63'd0};
	endfunction

	function automatic rounded_t predict_decimal_round(logic [63:0] vb, logic [5:0] dg);
		rounded_t    r;
		logic [63:0] sb;
		r.status = ddr_pkg::ST_OK;
		if (dg > ddr_pkg::MAX_DIGITS) begin
			r.status = ddr_pkg::ST_DIGITS;
			r.result_bits = 64'd0;
		end else if (vb[62:52] == ddr_pkg::EXP_ALL) begin
			r.status = ddr_pkg::ST_NOT_FINITE;
			r.result_bits = 64'd0;
		end else if (dg == 6'd0) begin
			r.result_bits = round_to_int_even(vb);
		end else begin
			sb = $realtobits($bitstoreal(vb) * ten_up[dg[3:0]]);
			if (sb[62:52] == ddr_pkg::EXP_ALL)
				r.result_bits = vb;
			else
				r.result_bits = $realtobits($bitstoreal(round_to_int_even(sb))
					* ten_down[dg[3:0]]);
		end
		if (r.status == ddr_pkg::ST_OK && r.result_bits[62:52] == ddr_pkg::EXP_ALL) begin
			r.status = ddr_pkg::ST_OVERFLOW;
			r.result_bits = 64'd0;
		end
		return r;
	endfunction

	// Mostly short gaps, sometimes long ones
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one transaction, hold it until accepted, record its expected result
	task automatic send_value(logic [63:0] vb, logic [5:0] dg, int gap);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.value_bits <= vb;
		din_if.fraction_digits <= dg;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		pending_results.push_back(predict_decimal_round(vb, dg));
	endtask

	// Check each result transaction and drive ready with random stalls
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		rounded_t want;
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (dout_if.valid && dout_if.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result bits=%h status=%0d", $time,
						dout_if.result_bits, dout_if.status);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (want.result_bits !== dout_if.result_bits) begin
						$display("%0t: result_bits expected %h actual %h", $time,
							want.result_bits, dout_if.result_bits);
						errors++;
					end
					if (want.status !== dout_if.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, dout_if.status);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				dout_if.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				dout_if.ready <= 1'b1;
				stall_left <= pick_gap();
			end
		end
	end

	task automatic test_directed();
		send_value(64'h0000000000000000, 6'd0, 0);
		send_value(64'h8000000000000000, 6'd3, 0);
		send_value($realtobits(0.5), 6'd0, 0);
		send_value($realtobits(1.5), 6'd0, 0);
		send_value($realtobits(2.5), 6'd0, 1);
		send_value($realtobits(-2.5), 6'd0, 0);
		send_value($realtobits(-0.3), 6'd0, 0);
		send_value($realtobits(0.49999999999999994), 6'd0, 0);
		send_value($realtobits(1.005), 6'd2, 0);
		send_value($realtobits(-0.125), 6'd2, 0);
		send_value($realtobits(3.14159265358979), 6'd15, 2);
		send_value(64'h7FEFFFFFFFFFFFFF, 6'd15, 0);
		send_value(64'hFFEFFFFFFFFFFFFF, 6'd1, 0);
		send_value(64'h0000000000000001, 6'd15, 0);
		send_value(64'h800FFFFFFFFFFFFF, 6'd0, 0);
		send_value(64'h4330000000000001, 6'd0, 0);
		send_value(64'h432FFFFFFFFFFFFF, 6'd0, 0);
		send_value(64'h7FF0000000000000, 6'd4, 0);
		send_value(64'hFFF0000000000000, 6'd0, 0);
		send_value(64'h7FF8000000000001, 6'd15, 0);
		send_value(64'hFFFFFFFFFFFFFFFF, 6'd2, 0);
		send_value(64'h7FF0000000000000, 6'd16, 0);
		send_value($realtobits(1.0), 6'd63, 0);
		send_value($realtobits(-7.25), 6'd1, 0);
		send_value($realtobits(123.456789), 6'd5, 0);
	endtask

	task automatic test_random(int count);
		logic [63:0] vb;
		logic [5:0]  dg;
		int          mode;
		repeat (count) begin
			mode = $urandom_range(0, 9);
			vb = {$urandom, $urandom};
			dg = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, ddr_pkg::MAX_DIGITS));
			case (mode)
				0, 1:
					;
				2, 3, 4, 5:
					// magnitudes where rounding changes the digits
					vb[62:52] = 11'($urandom_range(990, 1080));
				6:
					// halfway cases for integer rounding
					vb = $realtobits((real'($urandom_range(0, 1 << 20)) + 0.5)
						* (vb[63] ? -1.0 : 1.0));
				7:
					// small decimals with few digits
					vb = $realtobits(real'($signed($urandom)) * 1e-6);
				8:
					vb[62:52] = $urandom_range(0, 1) ? 11'd0 : ddr_pkg::EXP_ALL;
				default:
					// huge values where the scaled product may overflow
					vb[62:52] = 11'($urandom_range(2000, 2046));
			endcase
			send_value(vb, dg, pick_gap());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.value_bits = 64'd0;
		din_if.fraction_digits = 6'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1900);
		din_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("double_decimal_round_half_even_top verification clean");
		else
			$display("double_decimal_round_half_even_top verification failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5ms;
		$display("double_decimal_round_half_even_top verification failed");
		$finish;
	end

endmodule
